// ----- design/rgwc_pkg.sv -----
// ----------------------------------------------------------------------------
// rgwc_pkg
// Shared types, constants and helpers for the RTT gradient window control.
// ----------------------------------------------------------------------------
package rgwc_pkg;

	// Ring of send times: default number of entries.
	localparam int unsigned RING_DEPTH_DEF = 256;

	// Configuration port.
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 3;

	// Serial multiplier: signed multiplicand, unsigned multiplier, one bit a cycle.
	localparam int MUL_A_W = 48;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Serial divider: unsigned, one quotient bit a cycle.
	localparam int DIV_N_W = 48;
	localparam int DIV_D_W = 32;

	// Window in unsigned Q16.16.
	localparam logic [31:0] WIN_ONE   = 32'h0001_0000;
	localparam logic [31:0] WIN_RESET = 32'h003C_0000;

	// Limits of the smoothed RTT difference, held as 52-bit signed sums.
	localparam logic signed [51:0] D_MAX = 52'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [51:0] D_MIN = 52'shF_8000_0000_0000;

	// Statistics reset values.
	localparam logic signed [31:0] MIN_RTT_RESET  = 32'sd5000;
	localparam logic signed [31:0] PREV_RTT_RESET = 32'sd100;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW    = 3'd0,
		REG_HIGH   = 3'd1,
		REG_STEP   = 3'd2,
		REG_ALPHA  = 3'd3,
		REG_BETA   = 3'd4,
		REG_WARMUP = 3'd5,
		REG_GRAD   = 3'd6
	} cfg_reg_t;

	// Kind of window adjustment reported with each result.
	typedef enum logic [2:0] {
		ADJ_NONE     = 3'd0,
		ADJ_LOW_ADD  = 3'd1,
		ADJ_HIGH_CUT = 3'd2,
		ADJ_GRAD_ADD = 3'd3,
		ADJ_GRAD_CUT = 3'd4
	} adj_t;

	// Event kinds.
	localparam logic KIND_SEND = 1'b0;
	localparam logic KIND_ACK  = 1'b1;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SLOT,
		ST_READ,
		ST_EW1,
		ST_EW2,
		ST_ADD,
		ST_HDIV,
		ST_HMUL1,
		ST_HMUL2,
		ST_GDIV,
		ST_GMUL1,
		ST_GMUL2,
		ST_FIN
	} state_t;

	// Status of a serial arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	// Saturate a window result to 32 bits, then floor it at 1.0.
	function automatic logic [31:0] win_limit(input logic [49:0] v);
		logic [31:0] s;
		begin
			s = (v > 50'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
			win_limit = (s < WIN_ONE) ? WIN_ONE : s;
		end
	endfunction

endpackage

// ----- design/rgwc_ram.sv -----
// ----------------------------------------------------------------------------
// rgwc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rgwc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/rgwc_mul.sv -----
// ----------------------------------------------------------------------------
// rgwc_mul
// Bit-serial shift-add multiplier: signed multiplicand times unsigned
// multiplier, one multiplier bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module rgwc_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [rgwc_pkg::MUL_A_W-1:0] mcand,
	input  logic [rgwc_pkg::MUL_B_W-1:0]        mplier,
	output logic signed [rgwc_pkg::PROD_W-1:0]  product,
	output rgwc_pkg::unit_sts_t                 sts
);
	import rgwc_pkg::*;

	localparam int CNT_W = $clog2(MUL_B_W + 1);

	logic [CNT_W-1:0]          cnt_q;
	logic                      done_q;
	logic signed [MUL_A_W-1:0] a_q;
	logic [MUL_B_W-1:0]        b_q;
	logic signed [PROD_W-1:0]  acc_q;
	logic signed [PROD_W-1:0]  a_ext;

	assign a_ext = {{(PROD_W - MUL_A_W){a_q[MUL_A_W-1]}}, a_q};

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(MUL_B_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the multiplier out and accumulate the partial products.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= mcand;
			b_q   <= mplier;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			acc_q <= (acc_q <<< 1) + (b_q[MUL_B_W-1] ? a_ext : '0);
			b_q   <= {b_q[MUL_B_W-2:0], 1'b0};
		end
	end

	assign product  = acc_q;
	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;

endmodule

// ----- design/rgwc_div.sv -----
// ----------------------------------------------------------------------------
// rgwc_div
// Bit-serial restoring divider: unsigned dividend and divisor, one quotient
// bit per cycle. The divisor is never zero when the unit is started.
// ----------------------------------------------------------------------------
module rgwc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rgwc_pkg::DIV_N_W-1:0] dividend,
	input  logic [rgwc_pkg::DIV_D_W-1:0] divisor,
	output logic [rgwc_pkg::DIV_N_W-1:0] quotient,
	output logic [rgwc_pkg::DIV_D_W-1:0] remainder,
	output rgwc_pkg::unit_sts_t          sts
);
	import rgwc_pkg::*;

	localparam int CNT_W = $clog2(DIV_N_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [DIV_N_W-1:0] num_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W:0]   trial;
	logic [DIV_D_W:0]   diff;
	logic               qbit;

	// One trial subtraction per cycle.
	always_comb begin
		trial = {rem_q, num_q[DIV_N_W-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DIV_N_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend shifts out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[DIV_N_W-2:0], qbit};
			rem_q <= qbit ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
		end
	end

	assign quotient  = num_q;
	assign remainder = rem_q;
	assign sts.busy  = (cnt_q != '0);
	assign sts.done  = done_q;

endmodule

// ----- design/rtt_gradient_window_control.sv -----
// ----------------------------------------------------------------------------
// rtt_gradient_window_control
// Delay-gradient congestion window control driven by send and ack events.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat is one event (kind, seq_num, event_time) and yields
// exactly one output beat (window_datagrams, adjustment). Both channels use
// valid and stall; a beat moves when valid is high and stall is low.
// A send stores its time in a ring of RING_DEPTH entries; an ack reads it back,
// updates the RTT statistics and, after warm-up, adjusts the window.
// One event is processed at a time. The ring slot comes from a 48-step serial
// divider, and the statistics and window use the same divider and an 18-step
// serial multiplier. A gradient increase runs both the gradient divide and the
// step divide. The sequencer returns to idle in the cycle after the finished
// result loads into the output register, and takes the next event from then on.
// The result sits in an output register; the next event is taken while it
// waits, and the block holds its finished result until out_stall drops.
// Reset sets the registers to their defaults and the window to 60 datagrams;
// the ring is not cleared and needs no clearing pass.
// Configuration must be written on cfg_wr_en only while no event is in flight;
// the block leaves this rule to the user.
// ----------------------------------------------------------------------------
module rtt_gradient_window_control #(
	parameter int RING_DEPTH = rgwc_pkg::RING_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [rgwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rgwc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           kind,
	input  logic [31:0]                    seq_num,
	input  logic [31:0]                    event_time,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [15:0]                    window_datagrams,
	output logic [2:0]                     adjustment
);
	import rgwc_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);

	// Configuration registers.
	logic [15:0] low_q, high_q, alpha_q, beta_q, warmup_q, grad_q;
	logic [19:0] step_q;

	// Sequencer and statistics.
	state_t             state_q, state_d;
	adj_t               adj_q, adj_out_q;
	logic [31:0]        window_q;
	logic signed [47:0] d_q;
	logic signed [31:0] min_q, prev_q;
	logic               out_valid_q;
	logic [15:0]        win_out_q;

	// Captured event and intermediate values.
	logic               kind_q;
	logic [31:0]        seq_q, time_q;
	logic signed [31:0] rtt_q;
	logic signed [32:0] nd_q;
	logic signed [49:0] t1_q;

	// Unit interfaces.
	logic                      mul_start, div_start;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic signed [PROD_W-1:0]  mul_prod;
	unit_sts_t                 mul_sts, div_sts;
	logic [DIV_N_W-1:0]        div_n, div_quo;
	logic [DIV_D_W-1:0]        div_d, div_rem;
	logic                      ram_we, ram_re;
	logic [31:0]               ram_rdata;

	// Datapath values.
	logic               in_fire, out_load;
	logic signed [31:0] rtt_c;
	logic signed [51:0] sum_c, d_sat_c;
	logic [47:0]        d_abs_c;
	logic [31:0]        min_div_c, win_div_c;
	logic signed [48:0] g_c, gc_c;
	logic signed [50:0] m_c;
	logic               warm_c, low_c, high_c, grad_add_c;

	assign in_fire  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// Arithmetic that feeds the sequencer decisions.
	always_comb begin
		rtt_c     = $signed(time_q - ram_rdata);
		sum_c     = $signed({{4{d_q[47]}}, d_q}) - $signed({{2{t1_q[49]}}, t1_q})
			+ mul_prod[51:0];
		d_sat_c   = (sum_c > D_MAX) ? D_MAX : ((sum_c < D_MIN) ? D_MIN : sum_c);
		d_abs_c   = d_sat_c[47] ? 48'(-d_sat_c) : 48'(d_sat_c);
		min_div_c = (min_q > 32'sd0) ? 32'(min_q) : 32'd1;
		win_div_c = (window_q != '0) ? window_q : 32'd1;
		warm_c    = (seq_q < {16'h0, warmup_q});
		low_c     = (rtt_q < $signed({16'h0, low_q}));
		high_c    = (rtt_q > $signed({16'h0, high_q}));
		g_c       = d_q[47] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
		grad_add_c = (g_c <= -$signed({33'h0, grad_q}));
		gc_c      = (g_c > 49'sh1_0000_0000) ? 49'sh1_0000_0000 : g_c;
		m_c       = 51'sd65536 - $signed(mul_prod[65:16]);
	end

	// Next state and unit control.
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					div_start = 1'b1;
					div_n     = {16'h0, seq_num};
					div_d     = DIV_D_W'(RING_DEPTH);
					state_d   = ST_SLOT;
				end
			end
			ST_SLOT: begin
				if (div_sts.done) begin
					ram_we  = (kind_q == KIND_SEND);
					ram_re  = (kind_q == KIND_ACK);
					state_d = (kind_q == KIND_ACK) ? ST_READ : ST_FIN;
				end
			end
			ST_READ: begin
				mul_start = 1'b1;
				mul_a     = d_q;
				mul_b     = {2'b0, alpha_q};
				state_d   = ST_EW1;
			end
			ST_EW1: begin
				if (mul_sts.done) begin
					mul_start = 1'b1;
					mul_a     = {{15{nd_q[32]}}, nd_q};
					mul_b     = {2'b0, alpha_q};
					state_d   = ST_EW2;
				end
			end
			ST_EW2: begin
				if (mul_sts.done) begin
					if (warm_c) begin
						state_d = ST_FIN;
					end else if (low_c) begin
						div_start = 1'b1;
						div_n     = {12'h0, step_q, 16'h0};
						div_d     = win_div_c;
						state_d   = ST_ADD;
					end else if (high_c) begin
						div_start = 1'b1;
						div_n     = {16'h0, high_q, 16'h0};
						div_d     = 32'(rtt_q);
						state_d   = ST_HDIV;
					end else begin
						div_start = 1'b1;
						div_n     = d_abs_c;
						div_d     = min_div_c;
						state_d   = ST_GDIV;
					end
				end
			end
			ST_ADD: begin
				if (div_sts.done) begin
					state_d = ST_FIN;
				end
			end
			ST_HDIV: begin
				if (div_sts.done) begin
					mul_start = 1'b1;
					mul_a     = {32'h0, beta_q};
					mul_b     = 18'd65536 - {2'b0, div_quo[15:0]};
					state_d   = ST_HMUL1;
				end
			end
			ST_HMUL1: begin
				if (mul_sts.done) begin
					mul_start = 1'b1;
					mul_a     = {16'h0, window_q};
					mul_b     = 18'd65536 - {2'b0, mul_prod[31:16]};
					state_d   = ST_HMUL2;
				end
			end
			ST_GDIV: begin
				if (div_sts.done) begin
					if (grad_add_c) begin
						div_start = 1'b1;
						div_n     = {12'h0, step_q, 16'h0};
						div_d     = win_div_c;
						state_d   = ST_ADD;
					end else begin
						mul_start = 1'b1;
						mul_a     = gc_c[47:0];
						mul_b     = {2'b0, beta_q};
						state_d   = ST_GMUL1;
					end
				end
			end
			ST_GMUL1: begin
				if (mul_sts.done) begin
					if (m_c <= 51'sd0) begin
						state_d = ST_FIN;
					end else begin
						mul_start = 1'b1;
						mul_a     = {16'h0, window_q};
						mul_b     = m_c[17:0];
						state_d   = ST_GMUL2;
					end
				end
			end
			ST_HMUL2, ST_GMUL2: begin
				if (mul_sts.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes; indexes past the last register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= 16'd60;
			high_q   <= 16'd150;
			step_q   <= 20'd131072;
			alpha_q  <= 16'd3277;
			beta_q   <= 16'd13107;
			warmup_q <= 16'd20;
			grad_q   <= 16'd66;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LOW:    low_q    <= cfg_data[15:0];
				REG_HIGH:   high_q   <= cfg_data[15:0];
				REG_STEP:   step_q   <= cfg_data;
				REG_ALPHA:  alpha_q  <= cfg_data[15:0];
				REG_BETA:   beta_q   <= cfg_data[15:0];
				REG_WARMUP: warmup_q <= cfg_data[15:0];
				REG_GRAD:   grad_q   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Statistics, window and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WIN_RESET;
			d_q         <= '0;
			min_q       <= MIN_RTT_RESET;
			prev_q      <= PREV_RTT_RESET;
			adj_q       <= ADJ_NONE;
			adj_out_q   <= ADJ_NONE;
			win_out_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						adj_q <= ADJ_NONE;
					end
				end
				ST_READ: begin
					prev_q <= rtt_c;
					if (rtt_c <= min_q) begin
						min_q <= rtt_c;
					end
				end
				ST_EW2: begin
					if (mul_sts.done) begin
						d_q <= d_sat_c[47:0];
						if (!warm_c) begin
							adj_q <= low_c ? ADJ_LOW_ADD
								: (high_c ? ADJ_HIGH_CUT : ADJ_GRAD_CUT);
						end
					end
				end
				ST_GDIV: begin
					if (div_sts.done && grad_add_c) begin
						adj_q <= ADJ_GRAD_ADD;
					end
				end
				ST_ADD: begin
					if (div_sts.done) begin
						window_q <= win_limit(50'(window_q) + 50'(div_quo));
					end
				end
				ST_GMUL1: begin
					if (mul_sts.done && (m_c <= 51'sd0)) begin
						window_q <= WIN_ONE;
					end
				end
				ST_HMUL2, ST_GMUL2: begin
					if (mul_sts.done) begin
						window_q <= win_limit(mul_prod[65:16]);
					end
				end
				default: begin
				end
			endcase

			// Output register: a finished beat loads once the previous one is taken.
			if (out_load) begin
				out_valid_q <= 1'b1;
				win_out_q   <= window_q[31:16];
				adj_out_q   <= adj_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Event capture and per-ack intermediates.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= kind;
			seq_q  <= seq_num;
			time_q <= event_time;
		end
		if (state_q == ST_READ) begin
			rtt_q <= rtt_c;
			nd_q  <= 33'(rtt_c) - 33'(prev_q);
		end
		if ((state_q == ST_EW1) && mul_sts.done) begin
			t1_q <= mul_prod[65:16];
		end
	end

	assign out_valid        = out_valid_q;
	assign window_datagrams = win_out_q;
	assign adjustment       = adj_out_q;

	// Send-time ring.
	rgwc_ram #(
		.WIDTH (32),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (div_rem[AW-1:0]),
		.wdata (time_q),
		.re    (ram_re),
		.raddr (div_rem[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Shared serial multiplier.
	rgwc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_a),
		.mplier  (mul_b),
		.product (mul_prod),
		.sts     (mul_sts)
	);

	// Shared serial divider.
	rgwc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_n),
		.divisor   (div_d),
		.quotient  (div_quo),
		.remainder (div_rem),
		.sts       (div_sts)
	);

`ifndef SYNTH
	// The window never falls below one datagram.
	assert property (@(posedge clk) disable iff (!arst_n) window_q >= WIN_ONE)
		else $error("window below 1.0");

	// The multiplier and the divider are never busy together.
	assert property (@(posedge clk) disable iff (!arst_n) !(mul_sts.busy && div_sts.busy))
		else $error("arithmetic units overlap");

	// After the RTT sample is taken the minimum does not exceed it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (min_q <= prev_q))
		else $error("minimum RTT above latest sample");

	// An accepted event closes the input until its result is done.
	assert property (@(posedge clk) disable iff (!arst_n) in_fire |=> in_stall)
		else $error("input taken while busy");
`endif

endmodule
